/* design/mspg_pkg.sv */
// Shared types and constants of the step and direction pulse generator.
`default_nettype none
package mspg_pkg;

	localparam int DATA_W = 32;
	localparam int LINE_W = 9;

	// command codes
	localparam logic [2:0] CMD_TICK  = 3'd0;
	localparam logic [2:0] CMD_LOAD  = 3'd1;
	localparam logic [2:0] CMD_START = 3'd2;
	localparam logic [2:0] CMD_ABORT = 3'd3;
	localparam logic [2:0] CMD_WPOS  = 3'd4;
	localparam logic [2:0] CMD_WPER  = 3'd5;
	localparam logic [2:0] CMD_READ  = 3'd6;

	localparam logic [DATA_W-1:0] FIRST_EDGE     = 32'd50;
	localparam logic [DATA_W-1:0] PERIOD_DEFAULT = 32'd16000;
	localparam logic [DATA_W-1:0] PERIOD_LAST    = 32'd1072;
	localparam logic [LINE_W-1:0] INVERT_RESET   = 9'd316;

	typedef struct packed {
		logic [DATA_W-1:0] a;
		logic [DATA_W-1:0] b;
		logic              sub;
	} alu_req_t;

	typedef struct packed {
		logic [DATA_W-1:0] sum;
		logic              carry;
	} alu_rsp_t;

endpackage
`default_nettype wire

/* design/mspg_alu.sv */
// Shared 32-bit add, subtract and compare unit.
`default_nettype none
module mspg_alu (
	input  mspg_pkg::alu_req_t req,
	output mspg_pkg::alu_rsp_t rsp
);
	import mspg_pkg::*;

	logic [DATA_W:0] total;

	// subtract as a + ~b + 1; carry out high means a >= b (unsigned)
	assign total     = {1'b0, req.a} + {1'b0, req.b ^ {DATA_W{req.sub}}}
	                 + {{DATA_W{1'b0}}, req.sub};
	assign rsp.sum   = total[DATA_W-1:0];
	assign rsp.carry = total[DATA_W];

endmodule
`default_nettype wire

/* design/multi_axis_step_pulse_generator_unit.sv */
// Top level of the multi-channel step and direction pulse generator.
// A tick runs ST_TIME, then each channel through ST_PH0, ST_PH1 and ST_PH2 (one, two or
// three adder operations per channel); start: ST_PH0 and ST_PH1 per channel; abort:
// ST_PH0 per channel; load, write, read: ST_PH0 unless the channel is out of range;
// spare code: straight to ST_DONE. Busy stays high until idle, one request at a time.
// The receiver cannot stall: each result shows for the single cycle that done is high.
// Reset (arst_n low, asynchronous) clears channel state, sets default periods and mask.
`default_nettype none
module multi_axis_step_pulse_generator_unit #(
	parameter int CHANNELS = 9
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// request channel
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [2:0]                    command,
	input  wire logic [3:0]                    channel,
	input  wire logic signed [mspg_pkg::DATA_W-1:0] value,
	// invert mask write channel
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [mspg_pkg::LINE_W-1:0]   cfg_data,
	// result
	output logic                               done,
	output logic [mspg_pkg::LINE_W-1:0]        step_lines,
	output logic [mspg_pkg::LINE_W-1:0]        dir_lines,
	output logic                               busy_res,
	output logic signed [mspg_pkg::DATA_W-1:0] position_read
);
	import mspg_pkg::*;

	localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int EXT_W = (CHANNELS > LINE_W) ? CHANNELS : LINE_W;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CHANNELS - 1);
	localparam logic [4:0]       CH_LIM   = 5'(CHANNELS);

	// sequencer states
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_TIME = 3'd1;
	localparam logic [2:0] ST_PH0  = 3'd2;
	localparam logic [2:0] ST_PH1  = 3'd3;
	localparam logic [2:0] ST_PH2  = 3'd4;
	localparam logic [2:0] ST_DONE = 3'd5;

	logic [2:0]        state_q;
	logic [IDX_W-1:0]  idx_q;
	logic [2:0]        cmd_q;
	logic [DATA_W-1:0] val_q;
	logic [DATA_W-1:0] pos_rd_q;
	logic [DATA_W-1:0] time_now_q;
	logic [LINE_W-1:0] invert_q;

	// per-channel state; the arrays are read at the sweep index, the vectors also as a whole
	logic [DATA_W-1:0] position_q  [CHANNELS];
	logic [DATA_W-1:0] staged_q    [CHANNELS];
	logic [DATA_W-1:0] remaining_q [CHANNELS];
	logic [DATA_W-1:0] next_edge_q [CHANNELS];
	logic [DATA_W-1:0] period_q    [CHANNELS];
	logic [CHANNELS-1:0] step_level_q;
	logic [CHANNELS-1:0] fwd_q;
	logic [CHANNELS-1:0] dir_q;
	logic [CHANNELS-1:0] rem_nz_q;

	logic [EXT_W-1:0]    inv_ext;
	logic [CHANNELS-1:0] inv_vec;
	logic [EXT_W-1:0]    step_ext;
	logic [EXT_W-1:0]    dir_ext;
	logic                accept;
	logic                ch_ok;
	logic [DATA_W-1:0]   cur_staged;

	alu_req_t alu_req;
	alu_rsp_t alu_rsp;

	mspg_alu u_alu (
		.req(alu_req),
		.rsp(alu_rsp)
	);

	assign accept     = start && !busy;
	assign ch_ok      = {1'b0, channel} < CH_LIM;
	assign busy       = (state_q != ST_IDLE);
	assign cfg_ready  = 1'b1;
	assign cur_staged = staged_q[idx_q];

	// channels beyond the mask have no invert bit and no visible line
	assign inv_ext  = EXT_W'(invert_q);
	assign inv_vec  = inv_ext[CHANNELS-1:0];
	assign step_ext = EXT_W'(step_level_q);
	assign dir_ext  = EXT_W'(dir_q);

	assign done          = (state_q == ST_DONE);
	assign step_lines    = step_ext[LINE_W-1:0];
	assign dir_lines     = dir_ext[LINE_W-1:0];
	assign busy_res      = |rem_nz_q;
	assign position_read = pos_rd_q;

	// Operand selection for the shared adder: one operation per cycle.
	always_comb begin
		alu_req = '0;
		unique case (state_q)
			ST_TIME: begin
				// advance time by one before the sweep
				alu_req.a = time_now_q;
				alu_req.b = DATA_W'(1);
			end
			ST_PH0: begin
				unique case (cmd_q)
					CMD_TICK: begin
						// carry set when the edge time is not later than now
						alu_req.a   = time_now_q;
						alu_req.b   = next_edge_q[idx_q];
						alu_req.sub = 1'b1;
					end
					CMD_START: begin
						alu_req.a = position_q[idx_q];
						alu_req.b = cur_staged;
					end
					CMD_ABORT: begin
						// back out untravelled steps against the direction of travel
						alu_req.a   = position_q[idx_q];
						alu_req.b   = remaining_q[idx_q];
						alu_req.sub = fwd_q[idx_q];
					end
					default: alu_req = '0;
				endcase
			end
			ST_PH1: begin
				unique case (cmd_q)
					CMD_TICK: begin
						alu_req.a = next_edge_q[idx_q];
						alu_req.b = period_q[idx_q];
					end
					CMD_START: begin
						// magnitude: negate when the count is negative
						alu_req.a   = '0;
						alu_req.b   = cur_staged;
						alu_req.sub = cur_staged[DATA_W-1];
					end
					default: alu_req = '0;
				endcase
			end
			ST_PH2: begin
				// count off one step on a falling edge
				alu_req.a   = remaining_q[idx_q];
				alu_req.b   = DATA_W'(1);
				alu_req.sub = 1'b1;
			end
			default: alu_req = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			idx_q        <= '0;
			cmd_q        <= CMD_TICK;
			val_q        <= '0;
			pos_rd_q     <= '0;
			time_now_q   <= '0;
			invert_q     <= INVERT_RESET;
			step_level_q <= '0;
			fwd_q        <= '0;
			dir_q        <= '0;
			rem_nz_q     <= '0;
			for (int c = 0; c < CHANNELS; c++) begin
				position_q[c]  <= '0;
				staged_q[c]    <= '0;
				remaining_q[c] <= '0;
				next_edge_q[c] <= '0;
				period_q[c]    <= (c == CHANNELS - 1) ? PERIOD_LAST : PERIOD_DEFAULT;
			end
		end else begin
			if (cfg_valid && cfg_ready) begin
				invert_q <= cfg_data;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cmd_q    <= command;
						val_q    <= value;
						pos_rd_q <= '0;
						idx_q    <= '0;
						priority case (command)
							CMD_TICK: state_q <= ST_TIME;
							CMD_START: begin
								time_now_q <= '0;
								state_q    <= ST_PH0;
							end
							CMD_ABORT: state_q <= ST_PH0;
							CMD_LOAD, CMD_WPOS, CMD_WPER, CMD_READ: begin
								// single-channel request: drop it when out of range
								if (ch_ok) begin
									idx_q   <= channel[IDX_W-1:0];
									state_q <= ST_PH0;
								end else begin
									state_q <= ST_DONE;
								end
							end
							default: state_q <= ST_DONE;
						endcase
					end
				end
				ST_TIME: begin
					time_now_q <= alu_rsp.sum;
					state_q    <= ST_PH0;
				end
				ST_PH0: begin
					unique case (cmd_q)
						CMD_TICK: begin
							if (alu_rsp.carry && rem_nz_q[idx_q]) begin
								state_q <= ST_PH1;
							end else if (idx_q == LAST_IDX) begin
								state_q <= ST_DONE;
							end else begin
								idx_q <= idx_q + 1'b1;
							end
						end
						CMD_START: begin
							position_q[idx_q]  <= alu_rsp.sum;
							fwd_q[idx_q]       <= !cur_staged[DATA_W-1];
							dir_q[idx_q]       <= (|cur_staged)
							                   && (cur_staged[DATA_W-1] ^ inv_vec[idx_q]);
							next_edge_q[idx_q] <= FIRST_EDGE;
							state_q            <= ST_PH1;
						end
						CMD_ABORT: begin
							position_q[idx_q]  <= alu_rsp.sum;
							remaining_q[idx_q] <= '0;
							rem_nz_q[idx_q]    <= 1'b0;
							if (idx_q == LAST_IDX) begin
								state_q <= ST_DONE;
							end else begin
								idx_q <= idx_q + 1'b1;
							end
						end
						CMD_LOAD: begin
							staged_q[idx_q] <= val_q;
							state_q         <= ST_DONE;
						end
						CMD_WPOS: begin
							position_q[idx_q] <= val_q;
							state_q           <= ST_DONE;
						end
						CMD_WPER: begin
							period_q[idx_q] <= val_q;
							state_q         <= ST_DONE;
						end
						CMD_READ: begin
							pos_rd_q <= position_q[idx_q];
							state_q  <= ST_DONE;
						end
						default: state_q <= ST_DONE;
					endcase
				end
				ST_PH1: begin
					priority if (cmd_q == CMD_TICK) begin
						next_edge_q[idx_q] <= alu_rsp.sum;
						if (step_level_q[idx_q]) begin
							step_level_q[idx_q] <= 1'b0;
							state_q             <= ST_PH2;
						end else begin
							step_level_q[idx_q] <= 1'b1;
							if (idx_q == LAST_IDX) begin
								state_q <= ST_DONE;
							end else begin
								idx_q   <= idx_q + 1'b1;
								state_q <= ST_PH0;
							end
						end
					end else begin
						remaining_q[idx_q] <= alu_rsp.sum;
						rem_nz_q[idx_q]    <= |cur_staged;
						if (idx_q == LAST_IDX) begin
							state_q <= ST_DONE;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= ST_PH0;
						end
					end
				end
				ST_PH2: begin
					remaining_q[idx_q] <= alu_rsp.sum;
					rem_nz_q[idx_q]    <= |alu_rsp.sum;
					if (idx_q == LAST_IDX) begin
						state_q <= ST_DONE;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= ST_PH0;
					end
				end
				ST_DONE: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// the done strobe lasts one cycle and only ends a request in progress
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held for more than one cycle");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("accepted request did not start the sequencer");

	a_read_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && cmd_q != CMD_READ) |-> (position_read == '0))
		else $error("position_read nonzero outside a read request");

	a_nz_track: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (rem_nz_q[idx_q] == (remaining_q[idx_q] != '0)))
		else $error("remaining-step flag out of step with the count");

	a_time_reset: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && command == CMD_START) |=> (time_now_q == '0))
		else $error("start did not clear the time counter");

endmodule
`default_nettype wire
